FILE: hdl/swd_pkg.sv
`default_nettype none
package swd_pkg;

  localparam int unsigned GapW = 20;
  localparam int unsigned DataW = 32;
  localparam logic [GapW-1:0] ResyncGapReset = 20'd10000;
  localparam logic [5:0] ResetOnesMin = 6'd50;
  localparam logic [5:0] OnesRunMax = 6'd63;
  localparam logic [5:0] OnesRunReset = 6'd6;
  localparam logic [5:0] DataParityCount = 6'd33;
  localparam logic [2:0] AckOk = 3'd1;

  typedef enum logic [15:0] {
    PH_START  = 16'h0001,
    PH_APNDP  = 16'h0002,
    PH_RNW    = 16'h0004,
    PH_A2     = 16'h0008,
    PH_A3     = 16'h0010,
    PH_PARITY = 16'h0020,
    PH_STOP   = 16'h0040,
    PH_PARK   = 16'h0080,
    PH_TRN    = 16'h0100,
    PH_ACK0   = 16'h0200,
    PH_ACK1   = 16'h0400,
    PH_ACK2   = 16'h0800,
    PH_ACKTRN = 16'h1000,
    PH_DATA   = 16'h2000,
    PH_RST    = 16'h4000,
    PH_ENDTRN = 16'h8000
  } phase_t;

  typedef enum logic [3:0] {
    MK_NONE  = 4'd0,
    MK_START = 4'd1,
    MK_ONE   = 4'd2,
    MK_ZERO  = 4'd3,
    MK_DOT   = 4'd4,
    MK_EDOT  = 4'd5,
    MK_STOP  = 4'd6,
    MK_TURN  = 4'd7,
    MK_RESET = 4'd8
  } marker_t;

  typedef struct packed {
    marker_t          marker;
    logic             frame_valid;
    logic [3:0]       frame_command;
    logic [2:0]       frame_ack;
    logic [DataW-1:0] frame_data;
  } result_t;

  function automatic marker_t bit_marker(input logic b);
    return b ? MK_ONE : MK_ZERO;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/swd_decode.sv
`default_nettype none
module swd_decode
  import swd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            line_bit,
  input  wire logic [GapW-1:0] gap_ticks,
  input  wire logic [GapW-1:0] resync_gap,
  output result_t              result
);

  phase_t           phase_r, phase_nxt, phase_cur;
  logic [3:0]       cmd_r, cmd_nxt;
  logic [2:0]       ack_r, ack_nxt;
  logic [DataW-1:0] data_r, data_nxt;
  logic             par_r, par_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [5:0]       ones_r, ones_nxt;

  always_comb begin
    phase_cur = (gap_ticks > resync_gap) ? PH_START : phase_r;
    phase_nxt = phase_cur;
    cmd_nxt   = cmd_r;
    ack_nxt   = ack_r;
    data_nxt  = data_r;
    par_nxt   = par_r;
    cnt_nxt   = cnt_r;
    result    = '0;
    result.marker = MK_NONE;
    unique case (phase_cur)
      PH_START: begin
        if (line_bit) begin
          phase_nxt = PH_APNDP;
          result.marker = MK_START;
        end
      end
      PH_APNDP: begin
        par_nxt = line_bit;
        cmd_nxt[3] = line_bit;
        result.marker = bit_marker(line_bit);
        phase_nxt = PH_RNW;
      end
      PH_RNW: begin
        par_nxt = par_r ^ line_bit;
        cmd_nxt[2] = line_bit;
        result.marker = bit_marker(line_bit);
        phase_nxt = PH_A2;
      end
      PH_A2: begin
        par_nxt = par_r ^ line_bit;
        cmd_nxt[0] = line_bit;
        result.marker = bit_marker(line_bit);
        phase_nxt = PH_A3;
      end
      PH_A3: begin
        par_nxt = par_r ^ line_bit;
        cmd_nxt[1] = line_bit;
        result.marker = bit_marker(line_bit);
        phase_nxt = PH_PARITY;
      end
      PH_PARITY: begin
        if (par_r == line_bit) begin
          result.marker = MK_DOT;
          phase_nxt = PH_STOP;
        end else begin
          result.marker = MK_EDOT;
          phase_nxt = PH_RST;
        end
      end
      PH_STOP: begin
        if (line_bit) begin
          result.marker = MK_EDOT;
          phase_nxt = PH_RST;
        end else begin
          result.marker = MK_STOP;
          phase_nxt = PH_PARK;
        end
      end
      PH_PARK: begin
        phase_nxt = line_bit ? PH_TRN : PH_RST;
      end
      PH_TRN: begin
        result.marker = MK_TURN;
        phase_nxt = PH_ACK0;
      end
      PH_ACK0: begin
        ack_nxt[0] = line_bit;
        result.marker = bit_marker(line_bit);
        phase_nxt = PH_ACK1;
      end
      PH_ACK1: begin
        ack_nxt[1] = line_bit;
        result.marker = bit_marker(line_bit);
        phase_nxt = PH_ACK2;
      end
      PH_ACK2: begin
        phase_nxt = cmd_r[2] ? PH_DATA : PH_ACKTRN;
        cnt_nxt = '0;
        par_nxt = 1'b0;
        ack_nxt[2] = line_bit;
        result.marker = bit_marker(line_bit);
        result.frame_valid = (ack_nxt != AckOk);
      end
      PH_ACKTRN: begin
        result.marker = MK_TURN;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_nxt == DataParityCount) begin
          phase_nxt = cmd_r[2] ? PH_ENDTRN : PH_START;
          result.marker = (par_r == line_bit) ? MK_DOT : MK_EDOT;
          result.frame_valid = 1'b1;
        end else begin
          data_nxt = {line_bit, data_r[DataW-1:1]};
          par_nxt = par_r ^ line_bit;
          result.marker = bit_marker(line_bit);
        end
      end
      PH_ENDTRN: begin
        result.marker = MK_TURN;
        phase_nxt = PH_START;
      end
      PH_RST: begin
        if (ones_r >= ResetOnesMin) begin
          result.marker = MK_RESET;
          if (!line_bit) begin
            phase_nxt = PH_START;
          end
        end
      end
      default: begin
        phase_nxt = PH_RST;
      end
    endcase

    if (line_bit) begin
      ones_nxt = (ones_r < OnesRunMax) ? ones_r + 6'd1 : ones_r;
    end else begin
      ones_nxt = '0;
    end

    if (result.frame_valid) begin
      result.frame_command = cmd_nxt;
      result.frame_ack     = ack_nxt;
      result.frame_data    = data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RST;
      cmd_r   <= '0;
      ack_r   <= '0;
      data_r  <= '0;
      par_r   <= 1'b0;
      cnt_r   <= '0;
      ones_r  <= OnesRunReset;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      ack_r   <= ack_nxt;
      data_r  <= data_nxt;
      par_r   <= par_nxt;
      cnt_r   <= cnt_nxt;
      ones_r  <= ones_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/swd_transaction_decoder.sv
// Serial-wire-debug transaction decoder.
// The input channel carries one item per SWCLK rising edge: the sampled
// SWDIO level and the tick count since the previous edge. The result
// channel returns exactly one item per input item: a marker code for that
// edge and, on the last ack bit of a failed ack or on the data parity bit,
// a transaction frame with command, ack and data word.
// The configuration channel writes the resync gap; it is always ready and
// should be written only while the block is idle.
// An accepted item lands in an input register, is decoded against the
// packet state in one pass, and is written to the output register when
// it is free; one item is taken every cycle unless the receiver stalls.
// When the receiver stalls, the output register holds its item; the input
// register still takes one more item, after which in_ready drops until the
// output drains.
// Synchronous reset empties both registers, returns the decoder to the
// line reset phase and loads the resync gap with its default of 10000.
`default_nettype none
module swd_transaction_decoder
  import swd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_line_bit,
  input  wire logic [GapW-1:0]  in_gap_ticks,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            out_marker,
  output logic                  out_frame_valid,
  output logic [3:0]            out_frame_command,
  output logic [2:0]            out_frame_ack,
  output logic [DataW-1:0]      out_frame_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [GapW-1:0]  cfg_data
);

  logic            s1_valid_r;
  logic            s1_bit_r;
  logic [GapW-1:0] s1_gap_r;
  logic [GapW-1:0] resync_gap_r;
  logic            out_valid_r;
  result_t         res_r;
  result_t         res;
  logic            advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  swd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .line_bit   (s1_bit_r),
    .gap_ticks  (s1_gap_r),
    .resync_gap (resync_gap_r),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resync_gap_r <= ResyncGapReset;
    end else if (cfg_valid && cfg_ready) begin
      resync_gap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_bit_r <= in_line_bit;
      s1_gap_r <= in_gap_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_marker        = res_r.marker;
  assign out_frame_valid   = res_r.frame_valid;
  assign out_frame_command = res_r.frame_command;
  assign out_frame_ack     = res_r.frame_ack;
  assign out_frame_data    = res_r.frame_data;

endmodule
`default_nettype wire

FILE: hdl/swd_chk.sv
`default_nettype none
module swd_chk
  import swd_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [3:0]       out_marker,
  input wire logic             out_frame_valid,
  input wire logic [3:0]       out_frame_command,
  input wire logic [2:0]       out_frame_ack,
  input wire logic [DataW-1:0] out_frame_data
);

  // A stalled item keeps its marker and frame flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_marker)
      && $stable(out_frame_valid))
    else $error("stalled result item changed");

  // Without a frame all frame fields read as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |->
      out_frame_command == 4'd0 && out_frame_ack == 3'd0 && out_frame_data == '0)
    else $error("frame fields not cleared");

  // A frame with an OK ack is only reported on the data parity bit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid && out_frame_ack == AckOk |->
      out_marker == MK_DOT || out_marker == MK_EDOT)
    else $error("OK frame outside data parity bit");

  // An early frame comes on the last ack bit, which carries a bit marker.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid && out_frame_ack != AckOk |->
      out_marker == MK_DOT || out_marker == MK_EDOT
      || out_marker == MK_ONE || out_marker == MK_ZERO)
    else $error("frame on unexpected marker");

endmodule

bind swd_transaction_decoder swd_chk u_swd_chk (.*);
`default_nettype wire

FILE: tb/sv/swd_decode_board_pkg.sv
`timescale 1ns / 1ps
package swd_decode_board_pkg;
  import swd_pkg::*;

  class swd_decode_board;
    logic [GapW-1:0] resync_limit;
    phase_t stage;
    logic [3:0] request;
    logic [2:0] ack_code;
    logic [DataW-1:0] word;
    logic parity_acc;
    logic [5:0] beat_count;
    logic [5:0] high_run;
    result_t due_results[$];
    int mismatches;

    function new();
      resync_limit = ResyncGapReset;
      stage = PH_RST;
      request = '0;
      ack_code = '0;
      word = '0;
      parity_acc = 1'b0;
      beat_count = '0;
      high_run = OnesRunReset;
      mismatches = 0;
    endfunction

    function marker_t level_marker(logic b);
      return b ? MK_ONE : MK_ZERO;
    endfunction

    function void take_edge(logic b, logic [GapW-1:0] gap);
      result_t r;
      phase_t nxt;
      r = '0;
      r.marker = MK_NONE;
      if (gap > resync_limit) stage = PH_START;
      nxt = stage;
      case (stage)
        PH_START: begin
          if (b) begin
            nxt = PH_APNDP;
            r.marker = MK_START;
          end
        end
        PH_APNDP: begin
          parity_acc = b;
          request[3] = b;
          r.marker = level_marker(b);
          nxt = PH_RNW;
        end
        PH_RNW: begin
          parity_acc ^= b;
          request[2] = b;
          r.marker = level_marker(b);
          nxt = PH_A2;
        end
        PH_A2: begin
          parity_acc ^= b;
          request[0] = b;
          r.marker = level_marker(b);
          nxt = PH_A3;
        end
        PH_A3: begin
          parity_acc ^= b;
          request[1] = b;
          r.marker = level_marker(b);
          nxt = PH_PARITY;
        end
        PH_PARITY: begin
          if (parity_acc == b) begin
            r.marker = MK_DOT;
            nxt = PH_STOP;
          end else begin
            r.marker = MK_EDOT;
            nxt = PH_RST;
          end
        end
        PH_STOP: begin
          if (b) begin
            r.marker = MK_EDOT;
            nxt = PH_RST;
          end else begin
            r.marker = MK_STOP;
            nxt = PH_PARK;
          end
        end
        PH_PARK: begin
          nxt = b ? PH_TRN : PH_RST;
        end
        PH_TRN: begin
          r.marker = MK_TURN;
          nxt = PH_ACK0;
        end
        PH_ACK0: begin
          ack_code[0] = b;
          r.marker = level_marker(b);
          nxt = PH_ACK1;
        end
        PH_ACK1: begin
          ack_code[1] = b;
          r.marker = level_marker(b);
          nxt = PH_ACK2;
        end
        PH_ACK2: begin
          nxt = request[2] ? PH_DATA : PH_ACKTRN;
          beat_count = '0;
          parity_acc = 1'b0;
          r.marker = level_marker(b);
          ack_code[2] = b;
          if (ack_code != AckOk) r.frame_valid = 1'b1;
        end
        PH_ACKTRN: begin
          r.marker = MK_TURN;
          nxt = PH_DATA;
        end
        PH_DATA: begin
          beat_count = beat_count + 6'd1;
          if (beat_count == DataParityCount) begin
            nxt = request[2] ? PH_ENDTRN : PH_START;
            r.marker = (parity_acc == b) ? MK_DOT : MK_EDOT;
            r.frame_valid = 1'b1;
          end else begin
            word = {b, word[DataW-1:1]};
            parity_acc ^= b;
            r.marker = level_marker(b);
          end
        end
        PH_ENDTRN: begin
          r.marker = MK_TURN;
          nxt = PH_START;
        end
        default: begin
          if (high_run >= ResetOnesMin) begin
            r.marker = MK_RESET;
            if (!b) nxt = PH_START;
          end
        end
      endcase
      if (b) begin
        if (high_run < OnesRunMax) high_run = high_run + 6'd1;
      end else begin
        high_run = '0;
      end
      stage = nxt;
      if (r.frame_valid) begin
        r.frame_command = request;
        r.frame_ack = ack_code;
        r.frame_data = word;
      end
      due_results.push_back(r);
    endfunction

    function void check_marker(logic [3:0] mk, logic fv, logic [3:0] cmd, logic [2:0] ack,
                               logic [DataW-1:0] data);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing due: expected none, actual marker %0d", $time, mk);
        return;
      end
      want = due_results.pop_front();
      if (mk !== 4'(want.marker)) begin
        mismatches++;
        $display("%0t: marker: expected %0d, actual %0d", $time, want.marker, mk);
      end
      if (fv !== want.frame_valid) begin
        mismatches++;
        $display("%0t: frame_valid: expected %0d, actual %0d", $time, want.frame_valid, fv);
      end
      if (cmd !== want.frame_command) begin
        mismatches++;
        $display("%0t: frame_command: expected %h, actual %h", $time, want.frame_command, cmd);
      end
      if (ack !== want.frame_ack) begin
        mismatches++;
        $display("%0t: frame_ack: expected %h, actual %h", $time, want.frame_ack, ack);
      end
      if (data !== want.frame_data) begin
        mismatches++;
        $display("%0t: frame_data: expected %h, actual %h", $time, want.frame_data, data);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/swd_transaction_decoder_tb.sv
`timescale 1ns / 1ps
module swd_transaction_decoder_tb;
  import swd_pkg::*;
  import swd_decode_board_pkg::*;

  localparam int CycleLimit = 500000;

  logic clk;
  logic rst_n;
  logic in_valid;
  wire logic in_ready;
  logic in_line_bit;
  logic [GapW-1:0] in_gap_ticks;
  wire logic out_valid;
  logic out_ready;
  wire logic [3:0] out_marker;
  wire logic out_frame_valid;
  wire logic [3:0] out_frame_command;
  wire logic [2:0] out_frame_ack;
  wire logic [DataW-1:0] out_frame_data;
  logic cfg_valid;
  wire logic cfg_ready;
  logic [GapW-1:0] cfg_data;

  swd_decode_board board = new();
  int items_sent = 0;
  int cycle_count = 0;
  bit feed_burst = 1'b0;
  bit drain_burst = 1'b0;

  swd_transaction_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_line_bit(in_line_bit),
    .in_gap_ticks(in_gap_ticks),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_marker(out_marker),
    .out_frame_valid(out_frame_valid),
    .out_frame_command(out_frame_command),
    .out_frame_ack(out_frame_ack),
    .out_frame_data(out_frame_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic logic [GapW-1:0] calm_gap();
    int unsigned lim;
    lim = board.resync_limit;
    if ($urandom_range(0, 15) == 0) return GapW'($urandom_range(0, lim));
    return GapW'($urandom_range(0, lim < 20 ? lim : 20));
  endfunction

  function automatic logic [GapW-1:0] resync_jump();
    int unsigned lim;
    lim = board.resync_limit;
    if (lim == 32'hFFFFF) return '1;
    return GapW'($urandom_range(lim + 1, 32'hFFFFF));
  endfunction

  task automatic send_edge(input logic b, input logic [GapW-1:0] gap);
    int idle;
    logic took;
    if ($urandom_range(0, 63) == 0) feed_burst = !feed_burst;
    idle = feed_burst ? 0 : $urandom_range(0, 15);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_bit <= b;
    in_gap_ticks <= gap;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    board.take_edge(b, gap);
    items_sent++;
  endtask

  task automatic send_request(input logic [3:0] cmd, input logic parity_good);
    send_edge(cmd[3], calm_gap());
    send_edge(cmd[2], calm_gap());
    send_edge(cmd[0], calm_gap());
    send_edge(cmd[1], calm_gap());
    send_edge(^cmd ^ !parity_good, calm_gap());
  endtask

  task automatic drain_inputs();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_resync_gap(input logic [GapW-1:0] v);
    logic took;
    drain_inputs();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    board.resync_limit = v;
  endtask

  task automatic random_transaction();
    logic [3:0] cmd;
    logic [2:0] ack;
    logic [DataW-1:0] data;
    int lead;
    cmd = 4'($urandom);
    data = $urandom;
    case ($urandom_range(0, 7))
      4: ack = 3'd2;
      5: ack = 3'd4;
      6, 7: ack = 3'($urandom);
      default: ack = AckOk;
    endcase
    lead = (board.resync_limit == '1) ? 0 : $urandom_range(0, 3);
    if (lead == 0) begin
      repeat ($urandom_range(50, 70)) send_edge(1'b1, calm_gap());
      send_edge(1'b0, calm_gap());
    end
    send_edge(1'b1, lead >= 2 ? resync_jump() : calm_gap());
    send_request(cmd, $urandom_range(0, 7) != 0);
    send_edge($urandom_range(0, 15) == 0, calm_gap());
    send_edge($urandom_range(0, 15) != 0, calm_gap());
    send_edge(coin(), calm_gap());
    for (int k = 0; k < 3; k++) send_edge(ack[k], calm_gap());
    if (!cmd[2]) send_edge(coin(), calm_gap());
    for (int k = 0; k < DataW; k++) send_edge(data[k], calm_gap());
    send_edge(^data ^ ($urandom_range(0, 7) == 0), calm_gap());
    if (cmd[2]) send_edge(coin(), calm_gap());
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 6))
        send_edge(coin(), $urandom_range(0, 7) == 0 ? GapW'($urandom) : calm_gap());
    end
  endtask

  task automatic random_until(input int total);
    while (items_sent < total) random_transaction();
  endtask

  initial begin : drain_results
    int stall;
    logic fire;
    logic [3:0] mk;
    logic fv;
    logic [3:0] cmd;
    logic [2:0] ack;
    logic [DataW-1:0] data;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) drain_burst = !drain_burst;
      stall = drain_burst ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        fire = out_valid;
        mk = out_marker;
        fv = out_frame_valid;
        cmd = out_frame_command;
        ack = out_frame_ack;
        data = out_frame_data;
        @(posedge clk);
      end while (!fire);
      board.check_marker(mk, fv, cmd, ack, data);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_line_bit = 1'b0;
    in_gap_ticks = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A WAIT ack on a read reports the frame early with the old data word.
    send_edge(1'b0, '0);
    send_edge(1'b1, '1);
    send_request(4'b1110, 1'b1);
    send_edge(1'b0, 20'd3);
    send_edge(1'b1, 20'd3);
    send_edge(1'b0, 20'd3);
    send_edge(1'b0, 20'd3);
    send_edge(1'b1, 20'd3);
    send_edge(1'b0, 20'd3);
    // Bad request parity, then a bad stop bit, each after a forced restart.
    send_edge(1'b1, 20'd10001);
    send_request(4'b0001, 1'b0);
    send_edge(1'b1, 20'd20000);
    send_request(4'b0000, 1'b1);
    send_edge(1'b1, 20'd3);

    random_until(300);
    write_resync_gap('1);
    random_until(600);
    write_resync_gap('0);
    random_until(800);
    write_resync_gap(GapW'($urandom_range(1, 40)));
    random_until(1050);
    write_resync_gap(GapW'($urandom_range(41, 2000)));
    random_until(1300);

    drain_inputs();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
